[design/rpb_pkg.sv]
package rpb_pkg;

  localparam int COORD_BITS   = 12;
  localparam int RADIUS_DEPTH = 8192;
  localparam int COUNT_BITS   = 16;

  localparam int ADDR_BITS   = $clog2(RADIUS_DEPTH);
  localparam int DIFF_BITS   = (COORD_BITS > 12) ? COORD_BITS : 12;
  localparam int SQ_BITS     = 2 * DIFF_BITS;
  localparam int ROOT_BITS   = DIFF_BITS + 1;
  localparam int OPND_BITS   = 2 * ROOT_BITS;
  localparam int ITER_BITS   = $clog2(ROOT_BITS + 1);
  localparam int RADIUS_BITS = 13;
  localparam int SLOT_BITS   = 16;

  localparam logic [RADIUS_BITS-1:0] RADIUS_MAX = {RADIUS_BITS{1'b1}};

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_ROW   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_COL   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OVER_CODE    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IGN_CODE     = 3'd5;

endpackage

[design/radial_pixel_binning.sv]
// Radial pixel binning.
// Pixels enter in raster order on the input channel (in_valid / in_ready),
// one beat per pixel, with frame_start set on the first pixel of a frame.
// Each input beat yields exactly one output beat (out_valid / out_ready)
// carrying the radius from the configured origin, the pixel's slot in its
// ring, the pass-through value, the running largest radius and frame_done.
// Registers are written on the cfg channel, which is always ready, and
// should only be written while no pixel is in flight.
// The output beat of a pixel is registered in the update state, after the
// square, sum, root and read states, and in_ready returns in the same cycle
// as out_valid, so a new pixel is not accepted until the last one is presented.
// The bit-serial square root, one result bit per cycle, sets the rate.
// The ring counters live in one RAM of RADIUS_DEPTH entries. After reset and
// on every pixel with frame_start, a clearing pass writes zero to every
// entry before the pixel is processed; no pixel is accepted during the pass.
// A finished result waits in the output register while the receiver stalls;
// the next pixel is still accepted and runs until it needs that register.
module radial_pixel_binning (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rpb_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [rpb_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [15:0]                   pixel_value,
  input  logic                                 frame_start,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 accepted,
  output logic [rpb_pkg::RADIUS_BITS-1:0]      ring_radius,
  output logic [rpb_pkg::SLOT_BITS-1:0]        ring_slot,
  output logic signed [15:0]                   value_out,
  output logic [rpb_pkg::RADIUS_BITS-1:0]      max_radius,
  output logic                                 frame_done
);
  import rpb_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SQUARE, S_SUM, S_ROOT, S_READ, S_UPDATE
  } state_t;

  state_t state;

  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [11:0] origin_row;
  logic [11:0] origin_col;
  logic [15:0] over_code;
  logic [15:0] ign_code;

  logic [COORD_BITS-1:0] row_position;
  logic [COORD_BITS-1:0] col_position;
  logic [RADIUS_BITS-1:0] largest_radius;
  logic [ADDR_BITS-1:0] clr_addr;
  logic pend;

  logic [COORD_BITS-1:0] item_row;
  logic [COORD_BITS-1:0] item_col;
  logic item_acc;
  logic item_done;
  logic signed [15:0] item_value;

  logic [SQ_BITS-1:0] sq_row;
  logic [SQ_BITS-1:0] sq_col;
  logic [OPND_BITS-1:0] opnd;
  logic [ROOT_BITS+1:0] rem;
  logic [ROOT_BITS-1:0] root;
  logic [ITER_BITS-1:0] iter;

  logic [COUNT_BITS-1:0] ring_counts [RADIUS_DEPTH];
  logic [COUNT_BITS-1:0] rd_count;
  logic mem_we;
  logic [ADDR_BITS-1:0] mem_wa;
  logic [COUNT_BITS-1:0] mem_wd;

  logic [COORD_BITS-1:0] eff_row;
  logic [COORD_BITS-1:0] eff_col;
  logic row_end;
  logic last_row;
  logic [DIFF_BITS-1:0] row_a, row_b, col_a, col_b;
  logic [DIFF_BITS-1:0] d_row, d_col;
  logic [ROOT_BITS+1:0] rem_sh;
  logic [ROOT_BITS+1:0] trial;
  logic [RADIUS_BITS-1:0] radius;
  logic [ADDR_BITS-1:0] ring_addr;
  logic in_range;
  logic hit;
  logic count_full;
  logic can_go;
  logic [RADIUS_BITS-1:0] largest_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    eff_row  = frame_start ? '0 : row_position;
    eff_col  = frame_start ? '0 : col_position;
    row_end  = (32'(eff_col) + 32'd1 >= 32'(image_width)) || (&eff_col);
    last_row = (32'(eff_row) + 32'd1 >= 32'(image_height)) || (&eff_row);

    row_a = DIFF_BITS'(item_row);
    row_b = DIFF_BITS'(origin_row);
    col_a = DIFF_BITS'(item_col);
    col_b = DIFF_BITS'(origin_col);
    d_row = (row_a >= row_b) ? row_a - row_b : row_b - row_a;
    d_col = (col_a >= col_b) ? col_a - col_b : col_b - col_a;

    rem_sh = {rem[ROOT_BITS-1:0], opnd[OPND_BITS-1 -: 2]};
    trial  = {root, 2'b01};

    radius    = (32'(root) > 32'(RADIUS_MAX)) ? RADIUS_MAX : RADIUS_BITS'(root);
    ring_addr = ADDR_BITS'(radius);
    in_range  = 32'(radius) < 32'(RADIUS_DEPTH);
    hit        = item_acc && in_range;
    count_full = &rd_count;
    can_go     = !out_valid || out_ready;
    largest_next = (item_acc && (radius > largest_radius)) ? radius : largest_radius;

    mem_we = (state == S_CLEAR) ||
             ((state == S_UPDATE) && can_go && hit && !count_full);
    mem_wa = (state == S_CLEAR) ? clr_addr : ring_addr;
    mem_wd = (state == S_CLEAR) ? '0 : rd_count + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_counts[mem_wa] <= mem_wd;
    end
    if (state == S_READ) begin
      rd_count <= ring_counts[ring_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= 13'd4096;
      image_height   <= 13'd4096;
      origin_row     <= 12'd2048;
      origin_col     <= 12'd2048;
      over_code      <= 16'h7FFF;
      ign_code       <= 16'h8000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[12:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        REG_ORIGIN_ROW:   origin_row   <= cfg_data[11:0];
        REG_ORIGIN_COL:   origin_col   <= cfg_data[11:0];
        REG_OVER_CODE:    over_code    <= cfg_data;
        REG_IGN_CODE:     ign_code     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      pend           <= 1'b0;
      row_position   <= '0;
      col_position   <= '0;
      largest_radius <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr_addr == ADDR_BITS'(RADIUS_DEPTH - 1)) begin
            state <= pend ? S_SQUARE : S_IDLE;
            pend  <= 1'b0;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item_row   <= eff_row;
            item_col   <= eff_col;
            item_value <= pixel_value;
            item_acc   <= (pixel_value != over_code) && (pixel_value != ign_code);
            item_done  <= row_end && last_row;
            if (row_end && last_row) begin
              row_position <= '0;
              col_position <= '0;
            end else if (row_end) begin
              row_position <= eff_row + 1'b1;
              col_position <= '0;
            end else begin
              row_position <= eff_row;
              col_position <= eff_col + 1'b1;
            end
            if (frame_start) begin
              largest_radius <= '0;
              clr_addr       <= '0;
              pend           <= 1'b1;
              state          <= S_CLEAR;
            end else begin
              state <= S_SQUARE;
            end
          end
        end
        S_SQUARE: begin
          sq_row <= SQ_BITS'(d_row) * SQ_BITS'(d_row);
          sq_col <= SQ_BITS'(d_col) * SQ_BITS'(d_col);
          state  <= S_SUM;
        end
        S_SUM: begin
          opnd  <= OPND_BITS'(sq_row) + OPND_BITS'(sq_col);
          rem   <= '0;
          root  <= '0;
          iter  <= '0;
          state <= S_ROOT;
        end
        S_ROOT: begin
          opnd <= opnd << 2;
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[ROOT_BITS-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[ROOT_BITS-2:0], 1'b0};
          end
          iter <= iter + 1'b1;
          if (iter == ITER_BITS'(ROOT_BITS - 1)) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (can_go) begin
            out_valid      <= 1'b1;
            accepted       <= item_acc;
            ring_radius    <= radius;
            ring_slot      <= hit ? SLOT_BITS'(rd_count) : '0;
            value_out      <= item_value;
            max_radius     <= largest_next;
            frame_done     <= item_done;
            largest_radius <= largest_next;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[design/rpb_checker.sv]
module rpb_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             accepted,
  input logic [rpb_pkg::RADIUS_BITS-1:0]  ring_radius,
  input logic [rpb_pkg::SLOT_BITS-1:0]    ring_slot,
  input logic [rpb_pkg::RADIUS_BITS-1:0]  max_radius
);
  import rpb_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ring_slot) &&
      $stable(ring_radius) && $stable(max_radius) && $stable(accepted))
    else $error("output beat changed while stalled");

  a_reject_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> ring_slot == '0)
    else $error("rejected pixel reported a nonzero slot");

  a_max_covers: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> max_radius >= ring_radius)
    else $error("largest radius below an accepted radius");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("block not in clearing pass after reset");

endmodule

bind radial_pixel_binning rpb_checker u_rpb_checker (.*);

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import rpb_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [COUNT_BITS-1:0] COUNT_FULL = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic                   acc;
    logic [RADIUS_BITS-1:0] radius;
    logic [SLOT_BITS-1:0]   slot;
    logic [15:0]            value;
    logic [RADIUS_BITS-1:0] peak;
    logic                   done;
  } bin_result_t;

  typedef struct {
    logic [15:0] value;
    logic        start;
    int          gap;
    logic        hold;
  } pixel_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] pixel_value = '0;
  logic frame_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic accepted;
  logic [RADIUS_BITS-1:0] ring_radius;
  logic [SLOT_BITS-1:0] ring_slot;
  logic signed [15:0] value_out;
  logic [RADIUS_BITS-1:0] max_radius;
  logic frame_done;

  logic [12:0] cfg_width = 13'd4096;
  logic [12:0] cfg_height = 13'd4096;
  logic [COORD_BITS-1:0] org_row = 12'd2048;
  logic [COORD_BITS-1:0] org_col = 12'd2048;
  logic [15:0] tag_over = 16'h7FFF;
  logic [15:0] tag_ign = 16'h8000;
  logic [COUNT_BITS-1:0] ring_tally [RADIUS_DEPTH];
  logic [RADIUS_BITS-1:0] peak_radius = '0;
  logic [COORD_BITS-1:0] cur_row = '0;
  logic [COORD_BITS-1:0] cur_col = '0;

  pixel_beat_t pixel_backlog [$];
  bin_result_t predicted_bins [$];
  pixel_beat_t next_beat;
  bin_result_t want;
  logic feed_busy = 1'b0;
  logic gap_armed = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int idle_cap = 13;
  int mismatch_count = 0;
  int cycle_count = 0;

  radial_pixel_binning dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_value (pixel_value),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .accepted    (accepted),
    .ring_radius (ring_radius),
    .ring_slot   (ring_slot),
    .value_out   (value_out),
    .max_radius  (max_radius),
    .frame_done  (frame_done)
  );

  always #5 clk = ~clk;

  function automatic bin_result_t bin_pixel(logic [15:0] pix, logic start);
    bin_result_t res;
    int unsigned dr, dc, sumsq, rad, trial;
    logic [COUNT_BITS-1:0] slot;
    logic row_end, last_row;
    if (start) begin
      foreach (ring_tally[i]) ring_tally[i] = '0;
      peak_radius = '0;
      cur_row = '0;
      cur_col = '0;
    end
    dr = (cur_row >= org_row) ? cur_row - org_row : org_row - cur_row;
    dc = (cur_col >= org_col) ? cur_col - org_col : org_col - cur_col;
    sumsq = dr * dr + dc * dc;
    rad = 0;
    for (int b = RADIUS_BITS - 1; b >= 0; b--) begin
      trial = rad | (32'd1 << b);
      if (trial * trial <= sumsq) rad = trial;
    end
    slot = '0;
    res.acc = (pix != tag_over) && (pix != tag_ign);
    if (res.acc) begin
      if (rad > peak_radius) peak_radius = rad[RADIUS_BITS-1:0];
      if (rad < RADIUS_DEPTH) begin
        slot = ring_tally[rad];
        if (slot != COUNT_FULL) ring_tally[rad] = slot + 1'b1;
      end
    end
    row_end = (cur_col + 1 >= cfg_width) || (&cur_col);
    last_row = (cur_row + 1 >= cfg_height) || (&cur_row);
    res.radius = rad[RADIUS_BITS-1:0];
    res.slot = slot[SLOT_BITS-1:0];
    res.value = pix;
    res.peak = peak_radius;
    res.done = row_end && last_row;
    if (res.done) begin
      cur_row = '0;
      cur_col = '0;
    end else if (row_end) begin
      cur_col = '0;
      cur_row = cur_row + 1'b1;
    end else begin
      cur_col = cur_col + 1'b1;
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endfunction

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:  cfg_width = data[12:0];
      REG_IMAGE_HEIGHT: cfg_height = data[12:0];
      REG_ORIGIN_ROW:   org_row = data[COORD_BITS-1:0];
      REG_ORIGIN_COL:   org_col = data[COORD_BITS-1:0];
      REG_OVER_CODE:    tag_over = data;
      REG_IGN_CODE:     tag_ign = data;
      default: ;
    endcase
  endtask

  task automatic configure(int w, int h, int orow, int ocol, logic [15:0] ov, logic [15:0] ig);
    logic [15:0] d;
    d = 16'($urandom);
    d[12:0] = w[12:0];
    write_reg(REG_IMAGE_WIDTH, d);
    d = 16'($urandom);
    d[12:0] = h[12:0];
    write_reg(REG_IMAGE_HEIGHT, d);
    d = 16'($urandom);
    d[COORD_BITS-1:0] = orow[COORD_BITS-1:0];
    write_reg(REG_ORIGIN_ROW, d);
    d = 16'($urandom);
    d[COORD_BITS-1:0] = ocol[COORD_BITS-1:0];
    write_reg(REG_ORIGIN_COL, d);
    write_reg(REG_OVER_CODE, ov);
    write_reg(REG_IGN_CODE, ig);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_pixel(logic [15:0] v, logic s, logic hold);
    pixel_beat_t pb;
    pb.value = v;
    pb.start = s;
    pb.gap = $urandom_range(0, idle_cap);
    pb.hold = hold;
    pixel_backlog.push_back(pb);
  endtask

  task automatic wait_drain();
    while (pixel_backlog.size() != 0 || feed_busy || predicted_bins.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      feed_busy = 1'b0;
      gap_armed = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_bins.push_back(bin_pixel(pixel_value, frame_start));
        feed_busy = 1'b0;
      end
      if (!feed_busy && pixel_backlog.size() != 0) begin
        if (!gap_armed) begin
          gap_left = pixel_backlog[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!pixel_backlog[0].hold || predicted_bins.size() == 0) begin
          next_beat = pixel_backlog.pop_front();
          pixel_value <= next_beat.value;
          frame_start <= next_beat.start;
          feed_busy = 1'b1;
          gap_armed = 1'b0;
        end
      end
      in_valid <= feed_busy;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_bins.size() == 0) begin
          $display("%0t: result beat with no pixel pending", $time);
          mismatch_count++;
        end else begin
          want = predicted_bins.pop_front();
          check_field("accepted", 16'(want.acc), 16'(accepted));
          check_field("ring_radius", 16'(want.radius), 16'(ring_radius));
          check_field("ring_slot", want.slot, ring_slot);
          check_field("value_out", want.value, value_out);
          check_field("max_radius", 16'(want.peak), 16'(max_radius));
          check_field("frame_done", 16'(want.done), 16'(frame_done));
        end
        stall_left = $urandom_range(0, idle_cap);
      end else if (out_valid && stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int total, frame_no, npix, w, h, ew, eh, kind, stray, orow, ocol;
    logic [15:0] pv;
    logic [15:0] frame_a [12];
    frame_a = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'd100, 16'hFFFB,
                16'h5555, 16'hAAAA, 16'h0001, 16'h0002, 16'd100, 16'h0003};
    foreach (ring_tally[i]) ring_tally[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    idle_cap = 13;
    configure(4, 3, 1, 2, 16'd100, 16'hFFFB);
    for (int k = 0; k < 12; k++) push_pixel(frame_a[k], k == 0, 1'b0);
    for (int k = 0; k < 3; k++) push_pixel(frame_a[k + 6], 1'b0, 1'b0);
    push_pixel(16'h1234, 1'b1, 1'b0);
    push_pixel(16'hFFFB, 1'b0, 1'b0);
    push_pixel(16'h4321, 1'b0, 1'b0);
    wait_drain();
    write_reg(REG_SPARE_LO, 16'($urandom));
    write_reg(REG_SPARE_HI, 16'($urandom));
    configure(0, 0, 4095, 4095, 16'h8000, 16'h7FFF);
    push_pixel(16'h8000, 1'b1, 1'b0);
    push_pixel(16'h7FFF, 1'b0, 1'b0);
    push_pixel(16'h0000, 1'b0, 1'b0);
    push_pixel(16'h7FFE, 1'b0, 1'b0);
    wait_drain();

    idle_cap = 0;
    configure(8191, 1, 0, 4095, 16'h8000, 16'h7FFF);
    for (int k = 0; k < 40; k++) push_pixel(16'($urandom), k == 0, 1'b0);
    wait_drain();

    total = 0;
    frame_no = 0;
    while (total < 1000) begin
      case ($urandom_range(0, 9))
        0: w = 0;
        1: w = $urandom_range(4096, 8191);
        default: w = $urandom_range(1, 16);
      endcase
      case ($urandom_range(0, 9))
        0: h = 0;
        1: h = $urandom_range(4096, 8191);
        default: h = $urandom_range(1, 10);
      endcase
      ew = (w == 0) ? 1 : ((w > 4096) ? 4096 : w);
      eh = (h == 0) ? 1 : ((h > 4096) ? 4096 : h);
      if ($urandom_range(0, 1) == 0) begin
        orow = $urandom_range(0, 12);
        ocol = $urandom_range(0, 18);
      end else begin
        orow = $urandom_range(0, 4095);
        ocol = $urandom_range(0, 4095);
      end
      configure(w, h, orow, ocol, 16'($urandom), 16'($urandom));
      idle_cap = ($urandom_range(0, 3) == 0) ? 0 : 13;
      repeat ($urandom_range(1, 3)) begin
        npix = ew * eh;
        if (npix > 60) npix = $urandom_range(20, 60);
        kind = $urandom_range(0, 9);
        if (kind == 1) npix = $urandom_range(1, npix);
        if (kind == 3) npix += $urandom_range(1, 5);
        stray = (kind == 2) ? $urandom_range(1, npix) : -1;
        for (int k = 0; k < npix; k++) begin
          case ($urandom_range(0, 7))
            0: pv = tag_over;
            1: pv = tag_ign;
            default: pv = 16'($urandom);
          endcase
          push_pixel(pv, (k == 0 && kind != 0) || k == stray, k == 0 && frame_no % 4 == 1);
        end
        frame_no++;
        total += npix;
      end
      wait_drain();
    end

    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
